### hw/rtl/alm_pkg.sv
package alm_pkg;

  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned MS_W     = 10;
  localparam int unsigned ACC_W    = 11;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [COUNT_W-1:0] SNOOZE_LIMIT_RESET = 10'd300;

  typedef enum logic [STATUS_W-1:0] {
    ST_INACTIVE = 3'd0,
    ST_ACTIVE   = 3'd1,
    ST_PLAYING  = 3'd2,
    ST_SNOOZED  = 3'd3,
    ST_SNOOZING = 3'd4,
    ST_OFF      = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED = 3'd0,
    REG_HOUR    = 3'd1,
    REG_MINUTE  = 3'd2,
    REG_SECOND  = 3'd3,
    REG_LIMIT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic               enabled;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [COUNT_W-1:0] snooze_limit_s;
  } cfg_t;

  typedef struct packed {
    logic [HOUR_W-1:0] now_hour;
    logic [MIN_W-1:0]  now_minute;
    logic [SEC_W-1:0]  now_second;
    logic [MS_W-1:0]   elapsed_ms;
    logic              snooze_press;
    logic              off_press;
  } item_t;

endpackage

### hw/rtl/alm_cfg.sv
module alm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [alm_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [alm_pkg::CFG_DATA_W-1:0]   wr_data,
  output alm_pkg::cfg_t                    cfg
);

  alm_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enabled        <= 1'b0;
      regs.hour           <= '0;
      regs.minute         <= '0;
      regs.second         <= '0;
      regs.snooze_limit_s <= alm_pkg::SNOOZE_LIMIT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        alm_pkg::REG_ENABLED: regs.enabled        <= wr_data[0];
        alm_pkg::REG_HOUR:    regs.hour           <= wr_data[alm_pkg::HOUR_W-1:0];
        alm_pkg::REG_MINUTE:  regs.minute         <= wr_data[alm_pkg::MIN_W-1:0];
        alm_pkg::REG_SECOND:  regs.second         <= wr_data[alm_pkg::SEC_W-1:0];
        alm_pkg::REG_LIMIT:   regs.snooze_limit_s <= wr_data[alm_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### hw/rtl/alm_in_reg.sv
module alm_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            drain,
  input  alm_pkg::item_t  item_in,
  output logic            item_valid,
  output alm_pkg::item_t  item_out
);

  logic           valid;
  alm_pkg::item_t item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (drain) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

  assign item_valid = valid;
  assign item_out   = item;

endmodule

### hw/rtl/alm_core.sv
module alm_core #(
  parameter int unsigned MS_PER_SECOND = 1000
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  alm_pkg::item_t                 item,
  input  alm_pkg::cfg_t                  cfg,
  output alm_pkg::status_t               status_new,
  output logic [alm_pkg::COUNT_W-1:0]    seconds_new
);

  localparam logic [alm_pkg::ACC_W-1:0] MS_SEC = alm_pkg::ACC_W'(MS_PER_SECOND);

  alm_pkg::status_t               status;
  alm_pkg::status_t               status_next;
  logic [alm_pkg::ACC_W-1:0]      ms_acc;
  logic [alm_pkg::ACC_W-1:0]      ms_acc_next;
  logic [alm_pkg::COUNT_W-1:0]    sec_count;
  logic [alm_pkg::COUNT_W-1:0]    sec_count_next;

  logic [alm_pkg::ACC_W-1:0]      ms_clamped;
  logic [alm_pkg::ACC_W-1:0]      ms_sum;
  logic                           time_match;

  assign ms_clamped = ({1'b0, item.elapsed_ms} > MS_SEC) ? MS_SEC : {1'b0, item.elapsed_ms};
  assign ms_sum     = ms_acc + ms_clamped;
  assign time_match = (item.now_hour == cfg.hour) && (item.now_minute == cfg.minute) &&
                      (item.now_second == cfg.second);

  always_comb begin
    status_next    = status;
    ms_acc_next    = ms_acc;
    sec_count_next = sec_count;
    if (cfg.enabled) begin
      case (status)
        alm_pkg::ST_INACTIVE: begin
          if (time_match) begin
            status_next    = alm_pkg::ST_ACTIVE;
            ms_acc_next    = '0;
            sec_count_next = '0;
          end
        end
        alm_pkg::ST_ACTIVE: begin
          status_next = alm_pkg::ST_PLAYING;
        end
        alm_pkg::ST_PLAYING: begin
          if (item.snooze_press) begin
            status_next = alm_pkg::ST_SNOOZED;
          end else if (item.off_press) begin
            status_next = alm_pkg::ST_OFF;
          end
        end
        alm_pkg::ST_SNOOZED: begin
          status_next    = alm_pkg::ST_SNOOZING;
          ms_acc_next    = '0;
          sec_count_next = '0;
        end
        alm_pkg::ST_SNOOZING: begin
          if (sec_count >= cfg.snooze_limit_s) begin
            status_next    = alm_pkg::ST_ACTIVE;
            ms_acc_next    = '0;
            sec_count_next = '0;
          end else if (ms_sum > MS_SEC) begin
            sec_count_next = sec_count + 1'b1;
            ms_acc_next    = ms_sum - MS_SEC;
          end else begin
            ms_acc_next = ms_sum;
          end
          if (item.off_press) begin
            status_next = alm_pkg::ST_OFF;
          end
        end
        default: begin
          status_next = alm_pkg::ST_INACTIVE;
        end
      endcase
    end
  end

  always_comb begin
    status_new  = status_next;
    seconds_new = sec_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status    <= alm_pkg::ST_INACTIVE;
      ms_acc    <= '0;
      sec_count <= '0;
    end else if (step) begin
      status    <= status_next;
      ms_acc    <= ms_acc_next;
      sec_count <= sec_count_next;
    end
  end

endmodule

### hw/rtl/alarm_snooze_fsm.sv
// channel  direction  handshake            word
// in       to block   in_valid / in_stall   time of day, elapsed_ms, buttons
// out      from block out_valid / out_stall alarm_status, snooze_seconds
// cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one word per cycle while in_stall is low
// a result passes the input register and then the result register around the status update
// in_stall rises only while a result waits under out_stall with a word behind it
// cfg_ready is always high; rst is synchronous and restores snooze limit 300
module alarm_snooze_fsm #(
  parameter int unsigned MS_PER_SECOND = 1000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [alm_pkg::HOUR_W-1:0]        now_hour,
  input  logic [alm_pkg::MIN_W-1:0]         now_minute,
  input  logic [alm_pkg::SEC_W-1:0]         now_second,
  input  logic [alm_pkg::MS_W-1:0]          elapsed_ms,
  input  logic                              snooze_press,
  input  logic                              off_press,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [alm_pkg::STATUS_W-1:0]      alarm_status,
  output logic [alm_pkg::COUNT_W-1:0]       snooze_seconds,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [alm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [alm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  alm_pkg::cfg_t                  cfg;
  alm_pkg::item_t                 in_item;
  alm_pkg::item_t                 stage_item;
  logic                           stage_valid;
  logic                           stage_fire;
  logic                           out_free;
  logic                           in_fire;
  alm_pkg::status_t               status_new;
  logic [alm_pkg::COUNT_W-1:0]    seconds_new;
  logic                           out_vld;
  alm_pkg::status_t               out_status;
  logic [alm_pkg::COUNT_W-1:0]    out_seconds;

  assign cfg_ready = 1'b1;

  alm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign in_item.now_hour     = now_hour;
  assign in_item.now_minute   = now_minute;
  assign in_item.now_second   = now_second;
  assign in_item.elapsed_ms   = elapsed_ms;
  assign in_item.snooze_press = snooze_press;
  assign in_item.off_press    = off_press;

  assign out_free   = !out_vld || !out_stall;
  assign stage_fire = stage_valid && out_free;
  assign in_stall   = stage_valid && !out_free;
  assign in_fire    = in_valid && !in_stall;

  alm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (in_fire),
    .drain      (stage_fire),
    .item_in    (in_item),
    .item_valid (stage_valid),
    .item_out   (stage_item)
  );

  alm_core #(
    .MS_PER_SECOND (MS_PER_SECOND)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (stage_fire),
    .item        (stage_item),
    .cfg         (cfg),
    .status_new  (status_new),
    .seconds_new (seconds_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_free) begin
      out_vld <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire) begin
      out_status  <= status_new;
      out_seconds <= seconds_new;
    end
  end

  assign out_valid      = out_vld;
  assign alarm_status   = out_status;
  assign snooze_seconds = out_seconds;

`ifndef SYNTHESIS
  // no timing is left over once the alarm rings again
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    out_vld && (out_status == alm_pkg::ST_ACTIVE || out_status == alm_pkg::ST_PLAYING ||
                out_status == alm_pkg::ST_SNOOZED) |-> out_seconds == '0)
    else $error("snooze count not cleared outside a snooze");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_vld && out_stall)
    else $error("input stalled without a blocked result");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_stall && !stage_valid |=> !out_vld)
    else $error("result repeated after being taken");
`endif

endmodule
